/* rtl/assert_macros.svh */
// Assertion macros shared by the checker of the Hill cipher block.
// Depends on nothing; expects clk and arst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HC3_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hc3 check failed");

// Next-cycle implication, disabled while reset is asserted.
`define HC3_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hc3 check failed");

`endif

/* rtl/hc3_pkg.sv */
// Types and constants of the 3x3 mod 26 Hill cipher block.
// Depends on nothing; used by every module of the block.
package hc3_pkg;

	localparam int unsigned LetterW = 5;
	localparam int unsigned BlockLen = 3;
	localparam int unsigned KeyW = 45;
	localparam int unsigned SumW = 12;
	localparam logic [LetterW-1:0] PadLetter = 5'd23;
	localparam logic [SumW-1:0] Modulus = 12'd26;
	localparam logic [SumW-1:0] ModRecip = 12'd2521;
	localparam logic [KeyW-1:0] EncKeyReset = 45'd20962312099377;
	localparam logic [KeyW-1:0] DecKeyReset = 45'd18717687135524;

	typedef enum logic [1:0] {
		REG_DIRECTION = 2'd0,
		REG_ENC_KEY   = 2'd1,
		REG_DEC_KEY   = 2'd2,
		REG_NONE      = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [LetterW-1:0] letter;
		logic               last;
	} src_word_t;

	typedef struct packed {
		logic [LetterW-1:0] out_letter;
		logic               out_last;
	} dst_word_t;

	typedef struct packed {
		logic [BlockLen-1:0][LetterW-1:0] letters;
		logic                             last;
	} blk_t;

	typedef struct packed {
		logic valid;
		logic full;
	} q_status_t;

endpackage

/* rtl/hc3_front.sv */
// Front end: gathers letters into blocks of three and pads a closing partial block.
// Depends on hc3_pkg.
module hc3_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	input  hc3_pkg::src_word_t src_word,
	output logic              src_stall,
	input  hc3_pkg::q_status_t q_status,
	output logic              push,
	output hc3_pkg::blk_t     push_blk
);
	import hc3_pkg::*;

	logic [1:0]         fill_q;
	logic [LetterW-1:0] held0_q;
	logic [LetterW-1:0] held1_q;
	logic               accept;
	logic               close;

	assign src_stall = q_status.full;
	assign accept = src_valid && !src_stall;
	assign close = (fill_q >= 2'd2) || src_word.last;
	assign push = accept && close;

	always_comb begin
		push_blk.last = src_word.last;
		push_blk.letters[0] = PadLetter;
		push_blk.letters[1] = PadLetter;
		push_blk.letters[2] = PadLetter;
		unique case (fill_q)
			2'd0: begin
				push_blk.letters[0] = src_word.letter;
			end
			2'd1: begin
				push_blk.letters[0] = held0_q;
				push_blk.letters[1] = src_word.letter;
			end
			default: begin
				push_blk.letters[0] = held0_q;
				push_blk.letters[1] = held1_q;
				push_blk.letters[2] = src_word.letter;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 2'd0;
			held0_q <= '0;
			held1_q <= '0;
		end else if (accept) begin
			if (close) begin
				fill_q <= 2'd0;
				held0_q <= '0;
				held1_q <= '0;
			end else begin
				fill_q <= fill_q + 2'd1;
				if (fill_q == 2'd0) begin
					held0_q <= src_word.letter;
				end else begin
					held1_q <= src_word.letter;
				end
			end
		end
	end

endmodule

/* rtl/hc3_queue.sv */
// Two-entry block queue between the front end and the compute back end.
// Depends on hc3_pkg.
module hc3_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  hc3_pkg::blk_t      push_blk,
	input  logic               pop,
	output hc3_pkg::q_status_t q_status,
	output hc3_pkg::blk_t      head_blk
);
	import hc3_pkg::*;

	blk_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign q_status.valid = (count_q != 2'd0);
	assign q_status.full = (count_q == 2'd2);
	assign head_blk = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_blk;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

/* rtl/hc3_back.sv */
// Back end: a matrix row per cycle unless stalled: row sum, mod 26, output register.
// Depends on hc3_pkg.
module hc3_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [hc3_pkg::KeyW-1:0]   key,
	input  hc3_pkg::q_status_t         q_status,
	input  hc3_pkg::blk_t              head_blk,
	output logic                       pop,
	output logic                       dst_valid,
	output hc3_pkg::dst_word_t         dst_word,
	input  logic                       dst_stall
);
	import hc3_pkg::*;

	logic [1:0]                       row_q;
	logic                             valid_s1;
	logic [SumW-1:0]                  sum_s1;
	logic                             last_s1;
	logic                             valid_s2;
	dst_word_t                        word_s2;
	logic                             en_s1;
	logic                             en_s2;
	logic                             issue;
	logic [BlockLen-1:0][LetterW-1:0] row_key;
	logic [SumW-1:0]                  row_sum;
	logic [2*SumW-1:0]                recip_prod;
	logic [SumW-1:0]                  quot;
	logic [SumW-1:0]                  rem;

	assign en_s2 = !valid_s2 || !dst_stall;
	assign en_s1 = !valid_s1 || en_s2;
	assign issue = q_status.valid && en_s1;
	assign pop = issue && (row_q == 2'd2);

	always_comb begin
		unique case (row_q)
			2'd0: row_key = key[14:0];
			2'd1: row_key = key[29:15];
			default: row_key = key[44:30];
		endcase
		row_sum = SumW'(row_key[0]) * SumW'(head_blk.letters[0])
			+ SumW'(row_key[1]) * SumW'(head_blk.letters[1])
			+ SumW'(row_key[2]) * SumW'(head_blk.letters[2]);
		recip_prod = sum_s1 * ModRecip;
		quot = {4'd0, recip_prod[2*SumW-1:16]};
		rem = sum_s1 - SumW'(quot * Modulus);
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			sum_s1 <= row_sum;
			last_s1 <= head_blk.last && (row_q == 2'd2);
		end
		if (en_s2 && valid_s1) begin
			word_s2.out_letter <= rem[LetterW-1:0];
			word_s2.out_last <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= 2'd0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (issue) begin
				row_q <= (row_q == 2'd2) ? 2'd0 : row_q + 2'd1;
			end
			if (en_s1) begin
				valid_s1 <= issue;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	assign dst_valid = valid_s2;
	assign dst_word = word_s2;

endmodule

/* rtl/hill_cipher_3x3_mod26.sv */
// Top level of the 3x3 mod 26 Hill cipher: register file, front end, queue, back end.
// Depends on hc3_pkg, hc3_front, hc3_queue and hc3_back.
//
//   channel  direction  handshake            word
//   src      in         src_valid/src_stall  letter, last
//   dst      out        dst_valid/dst_stall  out_letter, out_last
//   config   in/out     APB psel/penable     64-bit data, registers at 0, 8, 16
//
// A letter is taken every cycle while the two-entry block queue has room.
// A closed block leaves as three words, one per cycle unless dst stalls, through the row-sum and output registers.
// The back end issues one matrix row per cycle unless stalled, which sets the sustained rate.
// A stall on dst holds the output register and backs up through the queue.
// Reset clears the register file to its reset keys and empties all stages.
module hill_cipher_3x3_mod26 (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	input  hc3_pkg::src_word_t src_word,
	output logic               src_stall,
	output logic               dst_valid,
	output hc3_pkg::dst_word_t dst_word,
	input  logic               dst_stall,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready
);
	import hc3_pkg::*;

	logic            direction_q;
	logic [KeyW-1:0] enc_key_q;
	logic [KeyW-1:0] dec_key_q;
	reg_idx_t        reg_idx;
	logic            wr_en;
	logic            push;
	blk_t            push_blk;
	blk_t            head_blk;
	logic            pop;
	q_status_t       q_status;

	assign pready = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[4:3]);
	assign wr_en = psel && penable && pwrite && pready;

	always_comb begin
		unique case (reg_idx)
			REG_DIRECTION: prdata = {63'd0, direction_q};
			REG_ENC_KEY: prdata = {19'd0, enc_key_q};
			REG_DEC_KEY: prdata = {19'd0, dec_key_q};
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= 1'b0;
			enc_key_q <= EncKeyReset;
			dec_key_q <= DecKeyReset;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_DIRECTION: direction_q <= pwdata[0];
				REG_ENC_KEY: enc_key_q <= pwdata[KeyW-1:0];
				REG_DEC_KEY: dec_key_q <= pwdata[KeyW-1:0];
				default: ;
			endcase
		end
	end

	hc3_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_word (src_word),
		.src_stall(src_stall),
		.q_status (q_status),
		.push     (push),
		.push_blk (push_blk)
	);

	hc3_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_blk(push_blk),
		.pop     (pop),
		.q_status(q_status),
		.head_blk(head_blk)
	);

	hc3_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.key      (direction_q ? dec_key_q : enc_key_q),
		.q_status (q_status),
		.head_blk (head_blk),
		.pop      (pop),
		.dst_valid(dst_valid),
		.dst_word (dst_word),
		.dst_stall(dst_stall)
	);

endmodule

/* rtl/hc3_checker.sv */
// Port-level checker of the Hill cipher block, bound to the top level.
// Depends on hc3_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hc3_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               dst_valid,
	input hc3_pkg::dst_word_t dst_word,
	input logic               dst_stall,
	input logic               psel,
	input logic               penable,
	input logic [63:0]        prdata,
	input logic               pready
);
	import hc3_pkg::*;

	// Every letter leaving the block has been reduced mod 26.
	`HC3_ASSERT_IMP(a_letter_range, dst_valid, dst_word.out_letter < 5'd26)
	// A stalled word stays offered unchanged.
	`HC3_ASSERT_NXT(a_dst_hold, dst_valid && dst_stall, dst_valid && $stable(dst_word))
	// Register reads never show bits above the widest register.
	`HC3_ASSERT_IMP(a_prdata_upper, psel, prdata[63:45] == 19'd0)
	// The configuration port never inserts wait states.
	`HC3_ASSERT_IMP(a_pready_high, psel && penable, pready)

endmodule

bind hill_cipher_3x3_mod26 hc3_checker u_hc3_checker (.*);

/* tb/hc3_checker.sv */
// Checker for the 3x3 mod 26 Hill cipher: snoops register writes and both word channels,
// predicts each output word and compares it with the oldest one still due.
// Depends on hc3_pkg.
module hc3_scoreboard (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	input  hc3_pkg::src_word_t src_word,
	input  logic               src_stall,
	input  logic               dst_valid,
	input  hc3_pkg::dst_word_t dst_word,
	input  logic               dst_stall,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [63:0]        pwdata,
	input  logic               pready,
	output int                 errors,
	output int                 pending
);
	import hc3_pkg::*;

	logic                              dir_q;
	logic [KeyW-1:0]                   enc_q;
	logic [KeyW-1:0]                   dec_q;
	logic [KeyW-1:0]                   key_v;
	logic [LetterW-1:0]                held_q [2];
	logic [BlockLen-1:0][LetterW-1:0]  blk_v;
	logic [1:0]                        fill_q;
	int unsigned                       sum_v;
	dst_word_t                         word_v;
	dst_word_t                         cipher_due [$];

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q = 1'b0;
			enc_q = EncKeyReset;
			dec_q = DecKeyReset;
			held_q[0] = '0;
			held_q[1] = '0;
			fill_q = '0;
			cipher_due.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:3])
					REG_DIRECTION: dir_q = pwdata[0];
					REG_ENC_KEY:   enc_q = pwdata[KeyW-1:0];
					REG_DEC_KEY:   dec_q = pwdata[KeyW-1:0];
					default: ;
				endcase
			end

			if (dst_valid && !dst_stall) begin
				if (cipher_due.size() == 0) begin
					errors++;
					$display("%0t: word with none due, expected none, actual letter %0d last %0b",
						$time, dst_word.out_letter, dst_word.out_last);
				end else begin
					word_v = cipher_due.pop_front();
					if (word_v.out_letter != dst_word.out_letter) begin
						errors++;
						$display("%0t: out_letter expected %0d actual %0d",
							$time, word_v.out_letter, dst_word.out_letter);
					end
					if (word_v.out_last != dst_word.out_last) begin
						errors++;
						$display("%0t: out_last expected %0b actual %0b",
							$time, word_v.out_last, dst_word.out_last);
					end
				end
			end

			if (src_valid && !src_stall) begin
				if (fill_q < 2'd2 && !src_word.last) begin
					held_q[fill_q[0]] = src_word.letter;
					fill_q++;
				end else begin
					// A short final block is padded with x in the empty positions.
					blk_v = {PadLetter, PadLetter, PadLetter};
					if (fill_q != 2'd0)
						blk_v[0] = held_q[0];
					if (fill_q == 2'd2)
						blk_v[1] = held_q[1];
					blk_v[fill_q] = src_word.letter;
					key_v = dir_q ? dec_q : enc_q;
					for (int r = 0; r < BlockLen; r++) begin
						sum_v = 0;
						for (int c = 0; c < BlockLen; c++)
							sum_v = sum_v + key_v[(r*BlockLen+c)*LetterW +: LetterW] * blk_v[c];
						word_v.out_letter = LetterW'(sum_v % Modulus);
						word_v.out_last = (r == BlockLen - 1) && src_word.last;
						cipher_due.push_back(word_v);
					end
					fill_q = '0;
					held_q[0] = '0;
					held_q[1] = '0;
				end
			end

			pending = cipher_due.size();
		end
	end

endmodule

/* tb/tb_hill_cipher_3x3_mod26.sv */
// Testbench top for the 3x3 mod 26 Hill cipher: clock, reset, register writes and letter
// stimulus with random gaps and stalls; the verdict comes from hc3_scoreboard.
// Depends on hc3_pkg, hc3_scoreboard and hill_cipher_3x3_mod26.
module tb_hill_cipher_3x3_mod26;
	import hc3_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               src_valid;
	src_word_t          src_word;
	logic               src_stall;
	logic               dst_valid;
	dst_word_t          dst_word;
	logic               dst_stall;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [4:0]         paddr;
	logic [63:0]        pwdata;
	logic [63:0]        prdata;
	logic               pready;
	int                 errors;
	int                 pending;
	bit                 quiet;
	int                 sent;
	int                 phase_end;
	int                 msg_len;
	logic [KeyW-1:0]    key25;

	hill_cipher_3x3_mod26 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_word  (src_word),
		.src_stall (src_stall),
		.dst_valid (dst_valid),
		.dst_word  (dst_word),
		.dst_stall (dst_stall),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	hc3_scoreboard chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_word  (src_word),
		.src_stall (src_stall),
		.dst_valid (dst_valid),
		.dst_word  (dst_word),
		.dst_stall (dst_stall),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.pready    (pready),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Output side: stall for a drawn number of cycles, then take one word.
	initial begin
		int hold;
		dst_stall = 1'b0;
		@(negedge clk);
		forever begin
			hold = quiet ? 0 : $urandom_range(0, 15);
			if (hold != 0) begin
				dst_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			dst_stall <= 1'b0;
			do @(posedge clk); while (!dst_valid);
			@(negedge clk);
		end
	end

	task automatic reg_write(input reg_idx_t idx, input logic [63:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_letter(input logic [LetterW-1:0] letter_in, input logic last_in);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		src_valid <= 1'b1;
		src_word <= '{letter: letter_in, last: last_in};
		do @(posedge clk); while (src_stall);
		sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		src_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	function automatic logic [LetterW-1:0] pick_letter();
		if ($urandom_range(0, 19) == 0)
			return LetterW'($urandom_range(26, 31));
		return LetterW'($urandom_range(0, 25));
	endfunction

	initial begin
		arst_n = 1'b0;
		src_valid = 1'b0;
		src_word = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		quiet = 1'b0;
		sent = 0;
		key25 = '0;
		for (int i = 0; i < 9; i++)
			key25[i*LetterW +: LetterW] = 5'd25;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset keys, encrypt: full blocks at the letter extremes, then last on
		// an empty, a one-letter and a two-letter block.
		send_letter(5'd0, 1'b0);
		send_letter(5'd0, 1'b0);
		send_letter(5'd0, 1'b0);
		send_letter(5'd25, 1'b0);
		send_letter(5'd25, 1'b0);
		send_letter(5'd25, 1'b0);
		send_letter(5'd31, 1'b0);
		send_letter(5'd31, 1'b0);
		send_letter(5'd31, 1'b0);
		send_letter(5'd5, 1'b1);
		send_letter(5'd7, 1'b0);
		send_letter(5'd9, 1'b1);
		send_letter(5'd1, 1'b0);
		send_letter(5'd2, 1'b0);
		send_letter(5'd3, 1'b1);
		drain();

		reg_write(REG_DIRECTION, 64'd1);
		reg_write(REG_NONE, {$urandom, $urandom});
		send_letter(5'd0, 1'b1);
		send_letter(5'd25, 1'b0);
		send_letter(5'd31, 1'b1);
		send_letter(5'd12, 1'b0);
		send_letter(5'd4, 1'b0);
		send_letter(5'd19, 1'b0);
		drain();

		reg_write(REG_ENC_KEY, '1);
		reg_write(REG_DEC_KEY, '0);
		reg_write(REG_DIRECTION, 64'd0);
		send_letter(5'd31, 1'b0);
		send_letter(5'd31, 1'b0);
		send_letter(5'd31, 1'b1);
		drain();

		for (int p = 0; p < 8; p++) begin
			case (p % 4)
				0: begin
					reg_write(REG_ENC_KEY, {$urandom, $urandom} | 64'h1FFF_FFFF_FFFF);
					reg_write(REG_DEC_KEY, {$urandom, 32'd0} & ~64'h1FFF_FFFF_FFFF);
				end
				1: begin
					reg_write(REG_ENC_KEY, {19'd0, key25});
					reg_write(REG_DEC_KEY, {$urandom, $urandom});
				end
				default: begin
					reg_write(REG_ENC_KEY, {$urandom, $urandom});
					reg_write(REG_DEC_KEY, {$urandom, $urandom});
				end
			endcase
			reg_write(REG_DIRECTION, {$urandom, $urandom});
			quiet = ($urandom_range(0, 3) == 0);
			phase_end = sent + 50;
			while (sent < phase_end) begin
				if ($urandom_range(0, 6) != 0) begin
					msg_len = $urandom_range(1, 10);
					for (int i = 0; i < msg_len; i++)
						send_letter(pick_letter(), i == msg_len - 1);
				end else begin
					msg_len = $urandom_range(1, 4);
					for (int i = 0; i < msg_len; i++)
						send_letter(LetterW'($urandom_range(0, 31)),
							1'($urandom_range(0, 1)));
				end
			end
			drain();
			quiet = 1'b0;
		end

		if (errors == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
